@@ rtl/core/ccr_pkg.sv @@
`default_nettype none

package ccr_pkg;

  localparam int DIM_BITS    = 12;
  localparam int COL_BITS    = DIM_BITS + 1;
  localparam int JQ_DEPTH    = 4;
  localparam int JQ_PTR_BITS = $clog2(JQ_DEPTH);
  localparam int CFG_IDX_BITS = 3;

  localparam logic [1:0] FMT_YUV422 = 2'd0;
  localparam logic [1:0] FMT_GRAY   = 2'd1;
  localparam logic [1:0] FMT_RGB565 = 2'd2;

  localparam logic [2:0] ORD_AUTO = 3'd0;
  localparam logic [2:0] ORD_YUYV = 3'd1;
  localparam logic [2:0] ORD_UYVY = 3'd2;
  localparam logic [2:0] ORD_YVYU = 3'd3;
  localparam logic [2:0] ORD_VYUY = 3'd4;

  localparam logic [1:0] SENS_YUYV = 2'd0;
  localparam logic [1:0] SENS_YVYU = 2'd1;
  localparam logic [1:0] SENS_UYVY = 2'd2;
  localparam logic [1:0] SENS_VYUY = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YUV_ORDER     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_ORDER  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_HEIGHT   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_CROP   = 3'd7;

  localparam logic [DIM_BITS-1:0] RST_SOURCE_WIDTH  = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] RST_SOURCE_HEIGHT = DIM_BITS'(240);
  localparam logic [DIM_BITS-1:0] RST_DEST_WIDTH    = DIM_BITS'(240);
  localparam logic [DIM_BITS-1:0] RST_DEST_HEIGHT   = DIM_BITS'(240);

  localparam logic [7:0] CHROMA_MID = 8'd128;
  localparam logic [7:0] LUMA_BLACK = 8'd16;

  // A YUV job carries two luma samples and shared chroma; any other job
  // carries finished color in y0 (red), u (green) and v (blue).
  typedef struct packed {
    logic                yuv;
    logic                two;
    logic [7:0]          y0;
    logic [7:0]          y1;
    logic [7:0]          u;
    logic [7:0]          v;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                fe0;
    logic                fe1;
  } job_t;

  function automatic logic [2:0] auto_order(input logic [1:0] sensor);
    logic [2:0] ord;
    case (sensor)
      SENS_YUYV: ord = ORD_YUYV;
      SENS_YVYU: ord = ORD_YVYU;
      SENS_UYVY: ord = ORD_UYVY;
      default:   ord = ORD_VYUY;
    endcase
    return ord;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [19:0] v);
    logic [7:0] r;
    if (v[19]) begin
      r = 8'd0;
    end else if (v[18:16] != 3'd0) begin
      r = 8'd255;
    end else begin
      r = v[15:8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ccr_front.sv @@
`default_nettype none

module ccr_front import ccr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  input  logic [7:0]              byte_in_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_addr_i,
  input  logic [DIM_BITS-1:0]     cfg_wdata_i,
  input  logic                    jq_full_i,
  output logic                    job_push_o,
  output job_t                    job_o
);

  logic [1:0]          fmt_q;
  logic [2:0]          yord_q;
  logic [1:0]          sord_q;
  logic [DIM_BITS-1:0] sw_q, sh_q, dw_q, dh_q;
  logic                cc_q;

  logic [COL_BITS-1:0] bc_q, bc_d;
  logic [DIM_BITS-1:0] sr_q, sr_d;
  logic [23:0]         gb_q, gb_d;
  logic [1:0]          gi_q, gi_d;
  logic [DIM_BITS-1:0] oc_q, oc_d;

  logic                accept, zero_size, bpp1, row_end, in_win, n0, n1, last_row;
  logic [COL_BITS-1:0] len, bx0, rel, y0h, wp1;
  logic [COL_BITS:0]   yuv_lim;
  logic [DIM_BITS-1:0] w, h, x0, y0, drow, oc1, wm1, hm1;
  logic [31:0]         gb32;
  logic [7:0]          g [4];
  logic [2:0]          ord;
  logic [7:0]          yv0, yv1, uv, vv;
  logic [15:0]         p565;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_YUV422;
      yord_q <= ORD_AUTO;
      sord_q <= SENS_YUYV;
      sw_q   <= RST_SOURCE_WIDTH;
      sh_q   <= RST_SOURCE_HEIGHT;
      dw_q   <= RST_DEST_WIDTH;
      dh_q   <= RST_DEST_HEIGHT;
      cc_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PIXEL_FORMAT:  fmt_q  <= cfg_wdata_i[1:0];
        CFG_YUV_ORDER:     yord_q <= cfg_wdata_i[2:0];
        CFG_SENSOR_ORDER:  sord_q <= cfg_wdata_i[1:0];
        CFG_SOURCE_WIDTH:  sw_q   <= cfg_wdata_i;
        CFG_SOURCE_HEIGHT: sh_q   <= cfg_wdata_i;
        CFG_DEST_WIDTH:    dw_q   <= cfg_wdata_i;
        CFG_DEST_HEIGHT:   dh_q   <= cfg_wdata_i;
        CFG_CENTER_CROP:   cc_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= '0;
      sr_q <= '0;
      gb_q <= '0;
      gi_q <= '0;
      oc_q <= '0;
    end else begin
      bc_q <= bc_d;
      sr_q <= sr_d;
      gb_q <= gb_d;
      gi_q <= gi_d;
      oc_q <= oc_d;
    end
  end

  always_comb begin
    accept    = push && !jq_full_i;
    zero_size = (sw_q == '0) || (sh_q == '0);
    bpp1      = (fmt_q == FMT_GRAY);
    len       = bpp1 ? {1'b0, sw_q} : {sw_q, 1'b0};
    row_end   = bc_q >= (len - 1'b1);
    w         = (sw_q < dw_q) ? sw_q : dw_q;
    h         = (sh_q < dh_q) ? sh_q : dh_q;
    x0        = cc_q ? ((sw_q - w) >> 1) : '0;
    y0        = cc_q ? ((sh_q - h) >> 1) : '0;
    bx0       = bpp1 ? {1'b0, x0} : {x0, 1'b0};
    y0h       = {1'b0, y0} + {1'b0, h};
    in_win    = (w != '0) && (h != '0) && (sr_q >= y0) && ({1'b0, sr_q} < y0h) &&
                (bc_q >= bx0);
    rel       = bc_q - bx0;
    drow      = sr_q - y0;
    wp1       = {1'b0, w} + 1'b1;
    yuv_lim   = {wp1[COL_BITS-1:1], 2'b00};
    oc1       = oc_q + 1'b1;
    wm1       = w - 1'b1;
    hm1       = h - 1'b1;
    n0        = oc_q < w;
    n1        = oc1 < w;
    last_row  = (drow == hm1);

    gb32 = {8'h00, gb_q};
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < gi_q) begin
        g[k] = gb32[8*k +: 8];
      end else if (2'(k) == gi_q) begin
        g[k] = byte_in_i;
      end else begin
        g[k] = CHROMA_MID;
      end
    end

    ord = (yord_q == ORD_AUTO) ? auto_order(sord_q) : yord_q;
    unique case (ord)
      ORD_UYVY: begin uv = g[0]; yv0 = g[1]; vv = g[2]; yv1 = g[3]; end
      ORD_YVYU: begin yv0 = g[0]; vv = g[1]; yv1 = g[2]; uv = g[3]; end
      ORD_VYUY: begin vv = g[0]; yv0 = g[1]; uv = g[2]; yv1 = g[3]; end
      default:  begin yv0 = g[0]; uv = g[1]; yv1 = g[2]; vv = g[3]; end
    endcase

    p565 = {byte_in_i, gb_q[7:0]};

    bc_d = bc_q;
    sr_d = sr_q;
    gb_d = gb_q;
    gi_d = gi_q;
    oc_d = oc_q;

    job_push_o = 1'b0;
    job_o.yuv  = 1'b0;
    job_o.two  = 1'b0;
    job_o.y0   = byte_in_i;
    job_o.y1   = byte_in_i;
    job_o.u    = byte_in_i;
    job_o.v    = byte_in_i;
    job_o.col  = oc_q;
    job_o.row  = drow;
    job_o.fe0  = (oc_q == wm1) && last_row;
    job_o.fe1  = (oc1 == wm1) && last_row;

    if (accept && !zero_size) begin
      if (in_win) begin
        if (fmt_q == FMT_YUV422 && {1'b0, rel} < yuv_lim) begin
          if (gi_q != 2'd3) begin
            gb_d = gb_q | ({16'h0000, byte_in_i} << {gi_q, 3'b000});
            gi_d = gi_q + 1'b1;
          end
          if (gi_q == 2'd3 || row_end) begin
            job_push_o = n0;
            job_o.yuv  = 1'b1;
            job_o.two  = n1;
            job_o.y0   = yv0;
            job_o.y1   = yv1;
            job_o.u    = uv;
            job_o.v    = vv;
            if (n0) begin
              oc_d = n1 ? (oc_q + 2'd2) : oc1;
            end
            gb_d = '0;
            gi_d = '0;
          end
        end else if (fmt_q == FMT_GRAY && rel < {1'b0, w}) begin
          job_push_o = n0;
          if (n0) begin
            oc_d = oc1;
          end
        end else if (fmt_q == FMT_RGB565 && rel < {w, 1'b0}) begin
          if (!gi_q[0]) begin
            gb_d = {16'h0000, byte_in_i};
            gi_d = 2'd1;
          end else begin
            job_push_o = n0;
            job_o.y0   = {p565[15:11], 3'b000};
            job_o.u    = {p565[10:5], 2'b00};
            job_o.v    = {p565[4:0], 3'b000};
            if (n0) begin
              oc_d = oc1;
            end
            gb_d = '0;
            gi_d = '0;
          end
        end
      end
      if (row_end) begin
        bc_d = '0;
        gb_d = '0;
        gi_d = '0;
        oc_d = '0;
        sr_d = (sr_q >= (sh_q - 1'b1)) ? '0 : (sr_q + 1'b1);
      end else begin
        bc_d = bc_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ccr_jobq.sv @@
`default_nettype none

module ccr_jobq import ccr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t data_o
);

  job_t                   mem_q [JQ_DEPTH];
  logic [JQ_PTR_BITS-1:0] wr_q, rd_q;
  logic [JQ_PTR_BITS:0]   cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == (JQ_PTR_BITS + 1)'(JQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ccr_back.sv @@
`default_nettype none

module ccr_back import ccr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                jq_empty_i,
  input  job_t                job_i,
  output logic                jq_pop_o,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [DIM_BITS-1:0] dest_col_o,
  output logic [DIM_BITS-1:0] dest_row_o,
  output logic                last_of_run_o,
  output logic                frame_end_o
);

  logic                sub_q;
  logic                ex_valid, ex_fire;
  logic [7:0]          ysel, c;
  logic signed [8:0]   d, e;
  logic [DIM_BITS-1:0] ex_col;
  logic                ex_fe, ex_last;

  logic                s1_v_q, s1_ready;
  logic                s1_yuv_q, s1_last_q, s1_fe_q;
  logic [7:0]          s1_r_q, s1_g_q, s1_b_q;
  logic [DIM_BITS-1:0] s1_col_q, s1_row_q;
  logic [16:0]         s1_pc_q;
  logic signed [18:0]  s1_re_q, s1_gd_q, s1_ge_q, s1_bd_q;

  logic                s2_v_q, s2_ready;
  logic signed [19:0]  rsum, gsum, bsum;

  assign ex_valid = !jq_empty_i;
  assign ex_fire  = ex_valid && s1_ready;
  assign jq_pop_o = ex_fire && (!job_i.two || sub_q);

  assign s2_ready = !s2_v_q || pop;
  assign s1_ready = !s1_v_q || s2_ready;
  assign empty    = !s2_v_q;

  always_comb begin
    ysel    = sub_q ? job_i.y1 : job_i.y0;
    c       = (ysel < LUMA_BLACK) ? 8'd0 : (ysel - LUMA_BLACK);
    d       = $signed({1'b0, job_i.u}) - 9'sd128;
    e       = $signed({1'b0, job_i.v}) - 9'sd128;
    ex_col  = job_i.col + DIM_BITS'(sub_q);
    ex_fe   = sub_q ? job_i.fe1 : job_i.fe0;
    ex_last = !job_i.two || sub_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (ex_fire) begin
        sub_q <= job_i.two && !sub_q;
      end
      if (s1_ready) begin
        s1_v_q <= ex_valid;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      s1_yuv_q  <= job_i.yuv;
      s1_last_q <= ex_last;
      s1_fe_q   <= ex_fe;
      s1_r_q    <= job_i.y0;
      s1_g_q    <= job_i.u;
      s1_b_q    <= job_i.v;
      s1_col_q  <= ex_col;
      s1_row_q  <= job_i.row;
      s1_pc_q   <= 17'(c) * 17'd298;
      s1_re_q   <= 19'(e) * 19'sd409;
      s1_gd_q   <= 19'(d) * 19'sd100;
      s1_ge_q   <= 19'(e) * 19'sd208;
      s1_bd_q   <= 19'(d) * 19'sd516;
    end
  end

  always_comb begin
    rsum = $signed({3'b000, s1_pc_q}) + 20'(s1_re_q) + 20'sd128;
    gsum = $signed({3'b000, s1_pc_q}) - 20'(s1_gd_q) - 20'(s1_ge_q) + 20'sd128;
    bsum = $signed({3'b000, s1_pc_q}) + 20'(s1_bd_q) + 20'sd128;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      red_o         <= s1_yuv_q ? clamp8(rsum) : s1_r_q;
      green_o       <= s1_yuv_q ? clamp8(gsum) : s1_g_q;
      blue_o        <= s1_yuv_q ? clamp8(bsum) : s1_b_q;
      dest_col_o    <= s1_col_q;
      dest_row_o    <= s1_row_q;
      last_of_run_o <= s1_last_q;
      frame_end_o   <= s1_fe_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/camera_crop_to_rgb888_top.sv @@
// Camera crop and RGB888 converter. Source frame bytes enter on the push/full queue port, one
// byte a cycle while not full, with no gaps required, and window pixels leave on the empty/pop
// port as 8-bit red, green and blue with their destination column and row. A byte is accepted
// while the four-entry job queue between the byte classifier and the color pipeline has room;
// a pixel passes through the job queue, the first color stage and the output registers, and the
// output delivers at most one pixel a cycle, so a YUV group of four bytes yields its two pixels
// one after the other. Formats, YUV byte order, frame sizes and centering are set through the
// write port and must be changed only while no pixel is in flight; the block does not check it.
`default_nettype none

module camera_crop_to_rgb888_top import ccr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              byte_in_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [DIM_BITS-1:0]     dest_col_o,
  output logic [DIM_BITS-1:0]     dest_row_o,
  output logic                    last_of_run_o,
  output logic                    frame_end_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_addr_i,
  input  logic [DIM_BITS-1:0]     cfg_wdata_i
);

  logic job_push, jq_pop, jq_empty;
  job_t job_in, job_out;

  ccr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .byte_in_i   (byte_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .jq_full_i   (full),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  ccr_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (jq_pop),
    .full_o  (full),
    .empty_o (jq_empty),
    .data_o  (job_out)
  );

  ccr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .jq_empty_i    (jq_empty),
    .job_i         (job_out),
    .jq_pop_o      (jq_pop),
    .empty         (empty),
    .pop           (pop),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .dest_col_o    (dest_col_o),
    .dest_row_o    (dest_row_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/ccr_checker.sv @@
`default_nettype none

module ccr_checker import ccr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty,
  input  logic                    pop,
  input  logic [7:0]              red_o,
  input  logic [7:0]              green_o,
  input  logic [7:0]              blue_o,
  input  logic [DIM_BITS-1:0]     dest_col_o,
  input  logic [DIM_BITS-1:0]     dest_row_o,
  input  logic                    last_of_run_o,
  input  logic                    frame_end_o
);

  logic out_beat;
  assign out_beat = pop && !empty;

  // The bottom-right pixel of the window always ends its run.
  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> last_of_run_o)
    else $error("frame end on a pixel that does not end its run");

  // The second pixel of a pair is already queued behind the first.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && !last_of_run_o) |=> !empty)
    else $error("second pixel of a pair missing");

  a_pair_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && !last_of_run_o) |=>
      (dest_col_o == $past(dest_col_o) + 1'b1) && (dest_row_o == $past(dest_row_o)))
    else $error("second pixel of a pair at the wrong position");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(red_o) && $stable(green_o) && $stable(blue_o)
                          && $stable(dest_col_o) && $stable(dest_row_o)))
    else $error("stalled result beat changed");

endmodule

bind camera_crop_to_rgb888_top ccr_checker u_ccr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .dest_col_o    (dest_col_o),
  .dest_row_o    (dest_row_o),
  .last_of_run_o (last_of_run_o),
  .frame_end_o   (frame_end_o)
);

`default_nettype wire
